[rtl/sms_pkg.sv]
// ----------------------------------------------------------------------------
// sms_pkg - shared types and constants of the subfield marker splitter
// Character codes, result kinds, input commands and the run descriptor that
// travels from the front end through the run queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

	// character codes of the marker syntax
	localparam logic [7:0] MARK_CHAR  = 8'h3F;	// '?'
	localparam logic [7:0] FEED_CHAR  = 8'h0A;	// line feed
	localparam logic [7:0] DIGIT_ZERO = 8'h30;	// '0'
	localparam logic [7:0] DIGIT_NINE = 8'h39;	// '9'

	// input commands (carried on s_axis_tuser)
	localparam logic CMD_TEXT = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// most results one input beat can cause
	localparam int MAX_RESULTS = 5;
	localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

	// default depth of the run queue
	localparam int QUEUE_DEPTH = 2;

	localparam int ID_W   = 7;
	localparam int BYTE_W = 8;

	typedef enum logic [1:0] {
		KIND_START    = 2'd0,
		KIND_CONTENT  = 2'd1,
		KIND_END_OK   = 2'd2,
		KIND_END_NONE = 2'd3
	} kind_t;

	// all results of one input beat: content bytes, then possibly one
	// closing result of kind last_kind in the final slot
	typedef struct packed {
		logic [RCNT_W-1:0]                 count;
		kind_t                             last_kind;
		logic [ID_W-1:0]                   id;
		logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
	} run_t;

endpackage

`default_nettype wire

[rtl/sms_front.sv]
// ----------------------------------------------------------------------------
// sms_front - marker matcher and run builder
// Accepts input beats, tracks the partly matched marker and turns each beat
// that causes results into one run descriptor for the run queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_front (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         in_cmd,
	input  wire logic [sms_pkg::BYTE_W-1:0]   in_byte,
	input  wire logic                         q_full,
	output logic                              q_push,
	output sms_pkg::run_t                     q_run
);

	typedef enum logic [4:0] {
		PH_IDLE    = 5'b00001,
		PH_MARK    = 5'b00010,
		PH_MARK_LF = 5'b00100,
		PH_TENS    = 5'b01000,
		PH_TENS_LF = 5'b10000
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [3:0]                   tens_q, tens_d;
	logic                         fam_q, fam_d;		// feed after '?'
	logic                         fad_q, fad_d;		// feed after tens digit
	logic                         inside_q, inside_d;
	logic [sms_pkg::ID_W-1:0]     id_q, id_d;
	logic                         saw_q, saw_d;

	logic                         accept;
	logic                         is_mark, is_feed, is_digit;
	logic [3:0]                   digit_val;
	logic [sms_pkg::ID_W-1:0]     new_id;
	logic                         complete, fail, idle, is_end;
	logic                         in_match, tens_held;
	logic [sms_pkg::RCNT_W-1:0]   n;
	sms_pkg::run_t                run;

	assign in_ready  = !q_full;
	assign accept    = in_valid && in_ready;
	assign is_mark   = in_byte == sms_pkg::MARK_CHAR;
	assign is_feed   = in_byte == sms_pkg::FEED_CHAR;
	assign is_digit  = in_byte inside {[sms_pkg::DIGIT_ZERO:sms_pkg::DIGIT_NINE]};
	assign digit_val = in_byte[3:0];
	assign new_id    = 7'({tens_q, 3'b000}) + 7'({tens_q, 1'b0}) + 7'(digit_val);
	assign is_end    = in_cmd == sms_pkg::CMD_END;
	assign in_match  = phase_q == PH_MARK || phase_q == PH_MARK_LF ||
	                   phase_q == PH_TENS || phase_q == PH_TENS_LF;
	assign tens_held = phase_q == PH_TENS || phase_q == PH_TENS_LF;

	always_comb begin
		phase_d  = phase_q;
		tens_d   = tens_q;
		fam_d    = fam_q;
		fad_d    = fad_q;
		inside_d = inside_q;
		id_d     = id_q;
		saw_d    = saw_q;
		complete = 1'b0;
		fail     = 1'b0;
		idle     = 1'b0;
		n        = '0;
		run      = '0;
		run.last_kind = sms_pkg::KIND_CONTENT;

		if (!is_end) begin
			case (phase_q)
				PH_MARK: begin
					if (is_feed) begin
						fam_d   = 1'b1;
						phase_d = PH_MARK_LF;
					end else if (is_digit) begin
						tens_d  = digit_val;
						phase_d = PH_TENS;
					end else begin
						fail = 1'b1;
					end
				end
				PH_MARK_LF: begin
					if (is_digit) begin
						tens_d  = digit_val;
						phase_d = PH_TENS;
					end else begin
						fail = 1'b1;
					end
				end
				PH_TENS: begin
					if (is_feed) begin
						fad_d   = 1'b1;
						phase_d = PH_TENS_LF;
					end else if (is_digit) begin
						complete = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				PH_TENS_LF: begin
					if (is_digit) begin
						complete = 1'b1;
					end else begin
						fail = 1'b1;
					end
				end
				default: begin
					idle = 1'b1;
				end
			endcase
		end

		// held characters go out as content on a failed match or at end of text
		if ((fail || is_end) && in_match && inside_q) begin
			run.bytes[n] = sms_pkg::MARK_CHAR;
			n = n + 1'b1;
			if (fam_q) begin
				run.bytes[n] = sms_pkg::FEED_CHAR;
				n = n + 1'b1;
			end
			if (tens_held) begin
				run.bytes[n] = {4'h3, tens_q};
				n = n + 1'b1;
				if (fad_q) begin
					run.bytes[n] = sms_pkg::FEED_CHAR;
					n = n + 1'b1;
				end
			end
		end

		// current character re-examined from idle
		if (fail || idle) begin
			phase_d = PH_IDLE;
			tens_d  = '0;
			fam_d   = 1'b0;
			fad_d   = 1'b0;
			if (is_mark) begin
				phase_d = PH_MARK;
			end else if (inside_q) begin
				run.bytes[n] = in_byte;
				n = n + 1'b1;
			end
		end

		if (complete) begin
			phase_d  = PH_IDLE;
			tens_d   = '0;
			fam_d    = 1'b0;
			fad_d    = 1'b0;
			inside_d = 1'b1;
			id_d     = new_id;
			run.last_kind = sms_pkg::KIND_START;
			n = n + 1'b1;
		end

		if (is_end) begin
			run.last_kind = (saw_q && !inside_q) ? sms_pkg::KIND_END_NONE
			                                     : sms_pkg::KIND_END_OK;
			n        = n + 1'b1;
			phase_d  = PH_IDLE;
			tens_d   = '0;
			fam_d    = 1'b0;
			fad_d    = 1'b0;
			inside_d = 1'b0;
			id_d     = '0;
			saw_d    = 1'b0;
		end else begin
			saw_d = 1'b1;
		end

		run.count = n;
		run.id    = complete ? new_id : id_q;
	end

	assign q_push = accept && (run.count != '0);
	assign q_run  = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			tens_q   <= '0;
			fam_q    <= 1'b0;
			fad_q    <= 1'b0;
			inside_q <= 1'b0;
			id_q     <= '0;
			saw_q    <= 1'b0;
		end else if (accept) begin
			phase_q  <= phase_d;
			tens_q   <= tens_d;
			fam_q    <= fam_d;
			fad_q    <= fad_d;
			inside_q <= inside_d;
			id_q     <= id_d;
			saw_q    <= saw_d;
		end
	end

endmodule

`default_nettype wire

[rtl/sms_queue.sv]
// ----------------------------------------------------------------------------
// sms_queue - run descriptor queue
// Short first-in first-out store between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_queue #(
	parameter int DEPTH = sms_pkg::QUEUE_DEPTH
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire sms_pkg::run_t  push_run,
	output logic                full,
	input  wire logic           pop,
	output sms_pkg::run_t       head,
	output logic                empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	sms_pkg::run_t       entries_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push, do_pop;

	assign full    = count_q == FULL_CNT;
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/sms_back.sv]
// ----------------------------------------------------------------------------
// sms_back - result sequencer
// Walks the head run of the queue and sends one result beat per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire sms_pkg::run_t               head,
	input  wire logic                        q_empty,
	output logic                             q_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output sms_pkg::kind_t                   out_kind,
	output logic [sms_pkg::ID_W-1:0]         out_id,
	output logic [sms_pkg::BYTE_W-1:0]       out_byte,
	output logic                             out_last
);

	logic [sms_pkg::RCNT_W-1:0] idx_q;
	logic                       beat;

	assign out_valid = !q_empty;
	assign out_last  = idx_q == (head.count - 1'b1);
	assign out_kind  = out_last ? head.last_kind : sms_pkg::KIND_CONTENT;
	assign out_id    = head.id;
	assign out_byte  = (out_kind == sms_pkg::KIND_CONTENT) ? head.bytes[idx_q] : '0;
	assign beat      = out_valid && out_ready;
	assign q_pop     = beat && out_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (beat) begin
			idx_q <= out_last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

[rtl/subfield_marker_splitter_unit.sv]
// ----------------------------------------------------------------------------
// subfield_marker_splitter_unit - splits a text stream into numbered subfields
// Finds markers '?' + two digits (optional line feed after '?' and after the
// first digit), opens subfield 0..99 on each, passes content and reports end.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata                          | tuser          | tlast
//  --------+-----+--------------------------------+----------------+-------------
//  s_axis  | in  | [7:0] text_byte                | [0] command    | -
//  m_axis  | out | [6:0] subfield_id,             | [1:0] kind     | last_of_run
//          |     | [14:7] content_byte, [15] zero |                |
//
//  One input beat per cycle while the queue has room; each gives 0 to 5 result
//  beats, sent one per cycle by the back end while m_axis_tready is high, so
//  the output port sets the pace once beats average more than one result.
//  The run queue (QUEUE_DEPTH runs) decouples the two sides: s_axis_tready
//  drops only when the queue is full.
//  Reset is asynchronous: match state, counters and queue clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module subfield_marker_splitter_unit #(
	parameter int QUEUE_DEPTH = sms_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,	// [7:0] text_byte
	input  wire logic [0:0]  s_axis_tuser,	// [0] command
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,	// [6:0] subfield_id, [14:7] content_byte
	output logic [1:0]       m_axis_tuser,	// [1:0] kind
	output logic             m_axis_tlast	// last_of_run
);

	// front end -> queue
	logic                           q_push;
	logic                           q_full;
	sms_pkg::run_t                  q_run;
	// queue -> back end
	sms_pkg::run_t                  q_head;
	logic                           q_empty;
	logic                           q_pop;
	// back end result fields
	sms_pkg::kind_t                 res_kind;
	logic [sms_pkg::ID_W-1:0]       res_id;
	logic [sms_pkg::BYTE_W-1:0]     res_byte;

	// matcher: classifies each beat and builds its run
	sms_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_cmd   (s_axis_tuser[0]),
		.in_byte  (s_axis_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_run    (q_run)
	);

	// runs waiting for the output side
	sms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_run (q_run),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	// sequencer: one result beat per cycle from the head run while the output is ready
	sms_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (res_kind),
		.out_id    (res_id),
		.out_byte  (res_byte),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, res_byte, res_id};
	assign m_axis_tuser = res_kind;

endmodule

`default_nettype wire

[rtl/sms_checker.sv]
// ----------------------------------------------------------------------------
// sms_checker - port-level checks of the subfield marker splitter
// Watches the result stream; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module sms_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic [1:0]  m_axis_tuser,
	input  wire logic        m_axis_tlast
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
			$stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// only content beats carry a byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != sms_pkg::KIND_CONTENT |->
			m_axis_tdata[14:7] == 8'h00)
		else $error("non-content beat carries a byte");

	// subfield start and end reports close their run
	a_close_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != sms_pkg::KIND_CONTENT |-> m_axis_tlast)
		else $error("closing kind without tlast");

	// subfield ids stay two-digit
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd99 && m_axis_tdata[15] == 1'b0)
		else $error("subfield id out of range");

endmodule

bind subfield_marker_splitter_unit sms_checker u_sms_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[verif/subfield_marker_splitter_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subfield_marker_splitter_unit_tb - self-checking bench for the splitter
// Drives text beats and end-of-text beats into the input stream and predicts
// every result beat with a cycle-free model of the marker matcher. Results
// are checked in order, field by field, under random idling and stalling on
// both streams, one long output hold-off and pauses until the output drains.
// ----------------------------------------------------------------------------

class subfield_scoreboard;

	typedef enum logic [2:0] {
		PH_IDLE,	// no marker held
		PH_MARK,	// '?' held
		PH_MARK_LF,	// '?' and line feed held
		PH_TENS,	// '?' and tens digit held
		PH_TENS_LF	// '?', tens digit and line feed held
	} match_phase_t;

	typedef struct {
		sms_pkg::kind_t                  kind;
		logic [sms_pkg::ID_W-1:0]        id;
		logic [sms_pkg::BYTE_W-1:0]      chr;
		logic                            last;
	} split_result_t;

	split_result_t expected_results[$];
	split_result_t beat_results[$];

	match_phase_t                phase;
	logic [3:0]                  tens;
	logic                        feed_mark;
	logic                        feed_digit;
	logic                        in_field;
	logic                        any_byte;
	logic [sms_pkg::ID_W-1:0]    field_id;
	int                          errors;

	function new();
		clear_text();
		errors = 0;
	endfunction

	function void clear_match();
		phase = PH_IDLE;
		tens = '0;
		feed_mark = 1'b0;
		feed_digit = 1'b0;
	endfunction

	function void clear_text();
		clear_match();
		in_field = 1'b0;
		field_id = '0;
		any_byte = 1'b0;
	endfunction

	function void emit(sms_pkg::kind_t kind, logic [sms_pkg::BYTE_W-1:0] chr);
		split_result_t r;
		r.kind = kind;
		r.id = field_id;
		r.chr = chr;
		r.last = 1'b0;
		beat_results.push_back(r);
	endfunction

	// text before the first marker is dropped
	function void content(logic [sms_pkg::BYTE_W-1:0] chr);
		if (in_field)
			emit(sms_pkg::KIND_CONTENT, chr);
	endfunction

	function bit is_digit(logic [sms_pkg::BYTE_W-1:0] chr);
		return chr >= sms_pkg::DIGIT_ZERO && chr <= sms_pkg::DIGIT_NINE;
	endfunction

	// a failed match or end of text gives the held characters back as content
	function void release_held();
		if (phase != PH_IDLE) begin
			content(sms_pkg::MARK_CHAR);
			if (feed_mark)
				content(sms_pkg::FEED_CHAR);
			if (phase >= PH_TENS) begin
				content(sms_pkg::DIGIT_ZERO + tens);
				if (feed_digit)
					content(sms_pkg::FEED_CHAR);
			end
		end
		clear_match();
	endfunction

	function void from_idle(logic [sms_pkg::BYTE_W-1:0] chr);
		if (chr == sms_pkg::MARK_CHAR) begin
			clear_match();
			phase = PH_MARK;
		end else
			content(chr);
	endfunction

	function void take_byte(logic [sms_pkg::BYTE_W-1:0] chr);
		case (phase)
			PH_MARK: begin
				if (chr == sms_pkg::FEED_CHAR) begin
					feed_mark = 1'b1;
					phase = PH_MARK_LF;
					return;
				end
				if (is_digit(chr)) begin
					tens = 4'(chr - sms_pkg::DIGIT_ZERO);
					phase = PH_TENS;
					return;
				end
			end
			PH_MARK_LF: begin
				if (is_digit(chr)) begin
					tens = 4'(chr - sms_pkg::DIGIT_ZERO);
					phase = PH_TENS;
					return;
				end
			end
			PH_TENS, PH_TENS_LF: begin
				if (phase == PH_TENS && chr == sms_pkg::FEED_CHAR) begin
					feed_digit = 1'b1;
					phase = PH_TENS_LF;
					return;
				end
				if (is_digit(chr)) begin
					field_id = 7'(tens * 10 + (chr - sms_pkg::DIGIT_ZERO));
					in_field = 1'b1;
					clear_match();
					emit(sms_pkg::KIND_START, '0);
					return;
				end
			end
			default: begin
				from_idle(chr);
				return;
			end
		endcase
		release_held();
		from_idle(chr);
	endfunction

	// accepted input beat: work out the result beats it causes
	function void note_text_beat(logic cmd, logic [sms_pkg::BYTE_W-1:0] chr);
		beat_results.delete();
		if (cmd == sms_pkg::CMD_TEXT) begin
			any_byte = 1'b1;
			take_byte(chr);
		end else begin
			release_held();
			emit((any_byte && !in_field) ? sms_pkg::KIND_END_NONE : sms_pkg::KIND_END_OK,
				'0);
			clear_text();
		end
		if (beat_results.size() > 0)
			beat_results[beat_results.size()-1].last = 1'b1;
		foreach (beat_results[i])
			expected_results.push_back(beat_results[i]);
	endfunction

	function int pending();
		return expected_results.size();
	endfunction

	task report(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	task check_result_beat(logic [15:0] data, logic [1:0] user, logic last);
		split_result_t want;
		if (expected_results.size() == 0) begin
			report($sformatf("unexpected beat kind %0d id %0d byte %02h",
				user, data[6:0], data[14:7]));
			return;
		end
		want = expected_results.pop_front();
		if (user !== want.kind)
			report($sformatf("kind %0d, want %s", user, want.kind.name()));
		if (data[6:0] !== want.id)
			report($sformatf("subfield id %0d, want %0d", data[6:0], want.id));
		if (data[14:7] !== want.chr)
			report($sformatf("content byte %02h, want %02h", data[14:7], want.chr));
		if (data[15] !== 1'b0)
			report("tdata pad bit not zero");
		if (last !== want.last)
			report($sformatf("last_of_run %b, want %b", last, want.last));
	endtask

endclass

module subfield_marker_splitter_unit_tb;

	localparam int RANDOM_ITEMS  = 80;
	localparam int HOLD_CYCLES   = 200;	// long output hold-off
	localparam int PRESSURE_BEATS = 12;	// beats offered during the hold-off
	localparam int SETTLE_CYCLES = 20;	// slack after the last result

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;		// [7:0] text_byte
	logic [0:0]  s_axis_tuser = sms_pkg::CMD_TEXT;	// [0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;		// [6:0] subfield_id, [14:7] content_byte, [15] zero
	logic [1:0]  m_axis_tuser;		// [1:0] kind
	logic        m_axis_tlast;		// last_of_run

	// idling per phase: none, sender only, receiver only, both
	int send_idle_tab[4]  = '{0, 53, 0, 33};
	int recv_stall_tab[4] = '{0, 0, 53, 33};

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;
	int beats_sent = 0;

	subfield_scoreboard sb;

	always #1 clk = ~clk;

	subfield_marker_splitter_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// one input beat; tvalid stays high straight into the next beat unless a gap is drawn
	task automatic send_beat(input logic cmd, input logic [7:0] chr);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= chr;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_text_beat(cmd, chr);
		beats_sent++;
	endtask

	task automatic send_str(input string s);
		foreach (s[i])
			send_beat(sms_pkg::CMD_TEXT, s[i]);
	endtask

	// sender stops until every predicted result has come out
	task automatic wait_drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] digit_char();
		return sms_pkg::DIGIT_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// content mix weighted towards the marker syntax
	function automatic logic [7:0] noise_char();
		case ($urandom_range(0, 9))
			0:       return sms_pkg::MARK_CHAR;
			1:       return sms_pkg::FEED_CHAR;
			2, 3:    return digit_char();
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// marker with random line feeds; now and then cut short by a stray character
	task automatic send_marker();
		logic [7:0] mk[$];
		int keep;
		mk = '{sms_pkg::MARK_CHAR};
		if ($urandom_range(99) < 30)
			mk.push_back(sms_pkg::FEED_CHAR);
		mk.push_back(digit_char());
		if ($urandom_range(99) < 30)
			mk.push_back(sms_pkg::FEED_CHAR);
		mk.push_back(digit_char());
		if ($urandom_range(99) < 20) begin
			keep = $urandom_range(1, mk.size() - 1);
			while (mk.size() > keep)
				void'(mk.pop_back());
			mk.push_back(noise_char());
		end
		foreach (mk[i])
			send_beat(sms_pkg::CMD_TEXT, mk[i]);
	endtask

	// one text: some leading junk, 0..3 subfields, end of text
	task automatic send_text();
		repeat ($urandom_range(0, 2))
			send_beat(sms_pkg::CMD_TEXT, noise_char());
		repeat ($urandom_range(0, 3)) begin
			send_marker();
			repeat ($urandom_range(0, 4))
				send_beat(sms_pkg::CMD_TEXT, noise_char());
		end
		send_beat(sms_pkg::CMD_END, 8'($urandom_range(0, 255)));
	endtask

	// result side: check accepted beats, then pick next tready
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		int target;
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty text ends fine
		send_beat(sms_pkg::CMD_END, 8'h00);
		// held marker before any subfield is dropped; bytes but no marker
		send_str("?1x");
		send_beat(sms_pkg::CMD_END, 8'hFF);
		// subfield 00 with a zero byte as content
		send_str("?00");
		send_beat(sms_pkg::CMD_TEXT, 8'h00);
		// line feeds in both places open 99; a full four-character hold
		// released by 'x' (five results); failure right after the mark;
		// '?' restarting a match; end of text flushing a held marker
		send_str("?\n9\n9?\n5\nx?A?\n?7\n");
		send_beat(sms_pkg::CMD_END, 8'h00);
		wait_drain();

		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_idle_tab[p];
			recv_stall_pct = recv_stall_tab[p];
			if (p == 0) begin
				// output held off while input keeps coming: queue fills, input stalls
				hold_req = 1'b1;
				target = beats_sent + PRESSURE_BEATS;
				while (beats_sent < target)
					send_text();
			end
			target = beats_sent + RANDOM_ITEMS / 4;
			while (beats_sent < target)
				send_text();
			wait_drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// watchdog, far beyond the slowest correct run
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
